FILE: design/rrpm_pkg.sv
// shared constants and controller/datapath interface types for the radial ring mask
package rrpm_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int CFG_W     = 13;
    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int PIX_W     = 8;
    localparam int SQ_W      = 2 * CNT_W;
    localparam int PROD_W    = 2 * SQ_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int ACC_W     = PROD_W + 9;
    localparam int J_W       = 5;
    localparam int J_LAST    = 15;
    localparam int MIN_DIM   = 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(300);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(227);

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic capture;
        logic mul_sq;
        logic mul_prod;
        logic sum;
        logic scale;
        logic iter;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic loop_go;
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        if (v < CFG_W'(MIN_DIM)) begin
            c = CFG_W'(MIN_DIM);
        end else if (v > CFG_W'(MAX_DIM)) begin
            c = CFG_W'(MAX_DIM);
        end else begin
            c = v;
        end
        return CNT_W'(c - CFG_W'(1));
    endfunction

endpackage

FILE: design/rrpm_ctrl.sv
// sequencer for one pixel: capture, squares, products, sum, scale, ring search, output
module rrpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrpm_pkg::t_sts i_sts,
    output rrpm_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SQ,
        S_MUL_PROD,
        S_SUM,
        S_SCALE,
        S_LOOP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL_SQ;
                end
            end
            S_MUL_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_MUL_PROD;
            end
            S_MUL_PROD: begin
                o_cmd.mul_prod = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.loop_go) begin
                    o_cmd.iter = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/rrpm_dp.sv
// datapath: config registers, raster counters, exact radius arithmetic and output register
module rrpm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [rrpm_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [rrpm_pkg::PIX_W-1:0]   i_blue_in,
    input  logic [rrpm_pkg::PIX_W-1:0]   i_green_in,
    input  logic [rrpm_pkg::PIX_W-1:0]   i_red_in,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rrpm_pkg::PIX_W-1:0]   o_blue_out,
    output logic [rrpm_pkg::PIX_W-1:0]   o_green_out,
    output logic [rrpm_pkg::PIX_W-1:0]   o_red_out,
    output logic                         o_end_of_frame,
    input  rrpm_pkg::t_cmd               i_cmd,
    output rrpm_pkg::t_sts               o_sts
);

    localparam int CNT_W  = rrpm_pkg::CNT_W;
    localparam int SQ_W   = rrpm_pkg::SQ_W;
    localparam int PROD_W = rrpm_pkg::PROD_W;
    localparam int NUM_W  = rrpm_pkg::NUM_W;
    localparam int ACC_W  = rrpm_pkg::ACC_W;
    localparam int PIX_W  = rrpm_pkg::PIX_W;
    localparam int J_W    = rrpm_pkg::J_W;

    logic [rrpm_pkg::CFG_W-1:0] r_width;
    logic [rrpm_pkg::CFG_W-1:0] r_height;
    logic [CNT_W-1:0]           r_col;
    logic [CNT_W-1:0]           r_row;

    logic [CNT_W-1:0]  lastx;
    logic [CNT_W-1:0]  lasty;
    logic [CNT_W-1:0]  x;
    logic [CNT_W-1:0]  y;
    logic [CNT_W:0]    tx;
    logic [CNT_W:0]    ty;
    logic [CNT_W-1:0]  dx;
    logic [CNT_W-1:0]  dy;

    logic [CNT_W-1:0]  r_dx;
    logic [CNT_W-1:0]  r_dy;
    logic [CNT_W-1:0]  r_lastx;
    logic [CNT_W-1:0]  r_lasty;
    logic [PIX_W-1:0]  r_blue;
    logic [PIX_W-1:0]  r_green;
    logic [PIX_W-1:0]  r_red;
    logic              r_eof;

    logic [SQ_W-1:0]   r_dxs;
    logic [SQ_W-1:0]   r_dys;
    logic [SQ_W-1:0]   r_dx2;
    logic [SQ_W-1:0]   r_dy2;
    logic [PROD_W-1:0] r_t1;
    logic [PROD_W-1:0] r_t2;
    logic [PROD_W-1:0] r_den;
    logic [NUM_W-1:0]  r_num;
    logic [ACC_W-1:0]  r_num100;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_step;
    logic [J_W-1:0]    r_j;
    logic              r_odd;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_blue_out;
    logic [PIX_W-1:0]  r_green_out;
    logic [PIX_W-1:0]  r_red_out;
    logic              r_eof_out;

    logic [ACC_W-1:0]  den_w;
    logic [ACC_W-1:0]  num_w;

    // clamp position into the frame and centre it
    always_comb begin
        lastx = rrpm_pkg::last_index(r_width);
        lasty = rrpm_pkg::last_index(r_height);
        x     = (r_col > lastx) ? lastx : r_col;
        y     = (r_row > lasty) ? lasty : r_row;
        tx    = {x, 1'b0};
        ty    = {y, 1'b0};
        dx    = (tx >= {1'b0, lastx}) ? CNT_W'(tx - {1'b0, lastx})
                                      : CNT_W'({1'b0, lastx} - tx);
        dy    = (ty >= {1'b0, lasty}) ? CNT_W'(ty - {1'b0, lasty})
                                      : CNT_W'({1'b0, lasty} - ty);
    end

    assign den_w = ACC_W'(r_den);
    assign num_w = ACC_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= rrpm_pkg::WIDTH_RST;
            r_height    <= rrpm_pkg::HEIGHT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rrpm_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    rrpm_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                if (x == lastx) begin
                    r_col <= '0;
                    r_row <= (y == lasty) ? '0 : CNT_W'(y + CNT_W'(1));
                end else begin
                    r_col <= CNT_W'(x + CNT_W'(1));
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dx    <= dx;
            r_dy    <= dy;
            r_lastx <= lastx;
            r_lasty <= lasty;
            r_blue  <= i_blue_in;
            r_green <= i_green_in;
            r_red   <= i_red_in;
            r_eof   <= (x == lastx) && (y == lasty);
        end
        if (i_cmd.mul_sq) begin
            r_dxs <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dys <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_dx2 <= SQ_W'(r_lastx) * SQ_W'(r_lastx);
            r_dy2 <= SQ_W'(r_lasty) * SQ_W'(r_lasty);
        end
        if (i_cmd.mul_prod) begin
            r_t1  <= PROD_W'(r_dxs) * PROD_W'(r_dy2);
            r_t2  <= PROD_W'(r_dys) * PROD_W'(r_dx2);
            r_den <= PROD_W'(r_dx2) * PROD_W'(r_dy2);
        end
        if (i_cmd.sum) begin
            r_num <= NUM_W'(r_t1) + NUM_W'(r_t2);
        end
        // 100 n as shifts; running j^2 d and (2j+1) d
        if (i_cmd.scale) begin
            r_num100 <= (num_w << 6) + (num_w << 5) + (num_w << 2);
            r_acc    <= den_w;
            r_step   <= (den_w << 1) + den_w;
            r_j      <= J_W'(1);
            r_odd    <= 1'b0;
        end
        if (i_cmd.iter) begin
            r_acc  <= r_acc + r_step;
            r_step <= r_step + (den_w << 1);
            r_j    <= J_W'(r_j + J_W'(1));
            r_odd  <= ~r_odd;
        end
        if (i_cmd.load_out) begin
            r_blue_out  <= r_odd ? '0 : r_blue;
            r_green_out <= r_odd ? '0 : r_green;
            r_red_out   <= r_odd ? '0 : r_red;
            r_eof_out   <= r_eof;
        end
    end

    assign o_sts.loop_go  = (r_j <= J_W'(rrpm_pkg::J_LAST)) && (r_num100 >= r_acc);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_blue_out     = r_blue_out;
    assign o_green_out    = r_green_out;
    assign o_red_out      = r_red_out;
    assign o_end_of_frame = r_eof_out;

endmodule

FILE: design/radial_ring_pixel_mask.sv
// top level of the radial ring pixel mask
// usage:
//   pixels enter in raster order on the input channel (i_in_valid / o_in_ready) and
//   leave on the output channel (o_out_valid / i_out_ready), one transaction out
//   for each transaction in, in order. column and row are counted inside against
//   image_width and image_height, written through the config port while idle.
//   a pixel passes when floor(10 r) is even and is blacked out otherwise;
//   o_end_of_frame marks the last pixel of each frame.
// sequencing:
//   one pixel is in flight at a time. a pixel goes through capture, squares, products,
//   sum, scale, k ring-search steps (k = floor(10 r) limited to 15) and the result
//   register; the next pixel can be accepted once that result has been loaded.
//   the ring search steps one ring boundary per cycle, adding to j^2 d and its step;
//   the squares and cross products take one multiplier stage each.
// stalls:
//   the result sits in an output register; the next pixel is accepted and worked
//   on while it waits, and the sequencer holds only if its own result is ready
//   before the previous one has been taken.
// reset:
//   synchronous, active low; counters go to zero, size registers to 300 x 227.
module radial_ring_pixel_mask (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [rrpm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rrpm_pkg::PIX_W-1:0]  i_blue_in,
    input  logic [rrpm_pkg::PIX_W-1:0]  i_green_in,
    input  logic [rrpm_pkg::PIX_W-1:0]  i_red_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rrpm_pkg::PIX_W-1:0]  o_blue_out,
    output logic [rrpm_pkg::PIX_W-1:0]  o_green_out,
    output logic [rrpm_pkg::PIX_W-1:0]  o_red_out,
    output logic                        o_end_of_frame
);

    rrpm_pkg::t_cmd cmd;
    rrpm_pkg::t_sts sts;

    rrpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrpm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_blue_in      (i_blue_in),
        .i_green_in     (i_green_in),
        .i_red_in       (i_red_in),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_blue_out     (o_blue_out),
        .o_green_out    (o_green_out),
        .o_red_out      (o_red_out),
        .o_end_of_frame (o_end_of_frame),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
